// ===== rtl/rcfl_pkg.sv =====
`timescale 1ns / 1ps
// rcfl_pkg: constants, opcodes, status codes and item types of the
// reference counted page free list; no dependencies

package rcfl_pkg;

  // sizes
  localparam int PAGES      = 8192;
  localparam int PAGE_BITS  = 13;
  localparam int DEPTH_BITS = 14;
  localparam int COUNT_BITS = 16;
  localparam int SUM_BITS   = COUNT_BITS + 2;
  localparam int COUNT_MAX  = (2 ** (COUNT_BITS - 1)) - 1;
  localparam int BATCH_MAX  = (2 ** DEPTH_BITS) - 1;

  // opcodes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_ADJUST  = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_NEG   = 3'd3;
  localparam logic [2:0] ST_OVF   = 3'd4;

  // request item
  typedef struct packed {
    logic [1:0]                   opcode;
    logic [PAGE_BITS-1:0]         page_id;
    logic signed [COUNT_BITS-1:0] count_delta;
    logic                         batch_end;
  } rcfl_req_t;

  // result item
  typedef struct packed {
    logic [2:0]            status;
    logic [PAGE_BITS-1:0]  result_page;
    logic                  page_was_freed;
    logic [DEPTH_BITS-1:0] batch_freed_total;
    logic [DEPTH_BITS-1:0] free_page_total;
  } rcfl_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
  } rcfl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } rcfl_stat_t;

endpackage

// ===== rtl/rcfl_ctrl.sv =====
`timescale 1ns / 1ps
// rcfl_ctrl: sequencer for the page free list; clearing pass, accept,
// execute and output handshake; depends on rcfl_pkg

module rcfl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  rcfl_pkg::rcfl_stat_t dp_stat,
  output rcfl_pkg::rcfl_cmd_t  cmd
);
  import rcfl_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // output register can take a new item
  assign out_free = !rsp_valid || !rsp_stall;

  // commands
  always_comb begin
    cmd.clear  = (state == S_CLEAR);
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.commit = (state == S_EXEC) && out_free;
  end

  assign req_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (dp_stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rcfl_dpath.sv =====
`timescale 1ns / 1ps
// rcfl_dpath: free stack and count memories, depth and batch registers,
// item evaluation and result register; depends on rcfl_pkg

module rcfl_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  rcfl_pkg::rcfl_cmd_t  cmd,
  input  rcfl_pkg::rcfl_req_t  req,
  output rcfl_pkg::rcfl_stat_t dp_stat,
  output rcfl_pkg::rcfl_rsp_t  rsp
);
  import rcfl_pkg::*;

  // memories
  logic [PAGE_BITS-1:0]  stack_mem [PAGES];
  logic [COUNT_BITS-1:0] count_mem [PAGES];

  // registers
  rcfl_req_t             item;
  logic [DEPTH_BITS-1:0] depth;
  logic [DEPTH_BITS-1:0] lowmark;
  logic [DEPTH_BITS-1:0] batch;
  logic [PAGE_BITS-1:0]  clr_addr;
  logic [PAGE_BITS-1:0]  stack_rd;
  logic [COUNT_BITS-1:0] count_rd;
  rcfl_rsp_t             rsp_reg;

  // evaluation
  logic [PAGE_BITS-1:0]        count_raddr;
  logic [PAGE_BITS-1:0]        stack_raddr;
  logic                        untouched;
  logic [PAGE_BITS-1:0]        pop_page;
  logic signed [SUM_BITS-1:0]  sum;
  logic                        sum_neg;
  logic                        sum_ovf;
  logic                        sum_zero;
  logic                        empty;
  logic                        full;
  logic [2:0]                  st;
  logic [PAGE_BITS-1:0]        rpage;
  logic                        freed;
  logic                        push;
  logic                        pop;
  logic                        cnt_we;
  logic                        inc_batch;
  logic                        close;
  logic [DEPTH_BITS-1:0]       depth_next;
  logic [DEPTH_BITS-1:0]       lowmark_next;
  logic [DEPTH_BITS-1:0]       batch_after;
  logic                        cmem_we;
  logic [PAGE_BITS-1:0]        cmem_waddr;
  logic [COUNT_BITS-1:0]       cmem_wdata;

  assign dp_stat.clear_last = (clr_addr == PAGE_BITS'(PAGES - 1));
  assign rsp = rsp_reg;

  // read addresses: count at the page being loaded or held, stack at top
  assign count_raddr = cmd.load ? req.page_id : item.page_id;
  assign stack_raddr = PAGE_BITS'(depth - 1'b1);

  // stack entries below the low-water mark are never written and read as their reset page
  assign untouched = (lowmark == depth);
  assign pop_page  = untouched ? stack_raddr : stack_rd;

  // count sum and its range checks
  assign sum = $signed({2'b00, count_rd}) +
               $signed({{2{item.count_delta[COUNT_BITS-1]}}, item.count_delta});
  assign sum_neg  = sum[SUM_BITS-1];
  assign sum_ovf  = !sum[SUM_BITS-1] && (sum[SUM_BITS-2:0] > (SUM_BITS-1)'(COUNT_MAX));
  assign sum_zero = (sum == '0);
  assign empty    = (depth == '0);
  assign full     = (depth == DEPTH_BITS'(PAGES));

  // item evaluation
  always_comb begin
    st        = ST_OK;
    rpage     = '0;
    freed     = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    cnt_we    = 1'b0;
    inc_batch = 1'b0;
    close     = 1'b0;
    case (item.opcode)
      OP_ALLOC: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          pop   = 1'b1;
          rpage = pop_page;
        end
      end
      OP_RELEASE: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          push  = 1'b1;
          rpage = item.page_id;
          freed = 1'b1;
        end
      end
      OP_ADJUST: begin
        close = item.batch_end;
        if (sum_neg) begin
          st = ST_NEG;
        end else if (sum_ovf) begin
          st = ST_OVF;
        end else if (sum_zero) begin
          if (full) begin
            st = ST_FULL;
          end else begin
            push      = 1'b1;
            cnt_we    = 1'b1;
            rpage     = item.page_id;
            freed     = 1'b1;
            inc_batch = 1'b1;
          end
        end else begin
          cnt_we = 1'b1;
        end
      end
      default: st = ST_OK;
    endcase
  end

  // depth, low-water mark and batch total after this item
  always_comb begin
    depth_next   = depth;
    lowmark_next = lowmark;
    if (push) begin
      depth_next = depth + 1'b1;
    end else if (pop) begin
      depth_next = depth - 1'b1;
      if (untouched) lowmark_next = depth - 1'b1;
    end
    batch_after = batch;
    if (inc_batch && (batch != DEPTH_BITS'(BATCH_MAX))) batch_after = batch + 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= DEPTH_BITS'(PAGES);
      lowmark  <= DEPTH_BITS'(PAGES);
      batch    <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (cmd.commit) begin
        depth   <= depth_next;
        lowmark <= lowmark_next;
        batch   <= close ? '0 : batch_after;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) item <= req;
    if (cmd.commit) begin
      rsp_reg.status            <= st;
      rsp_reg.result_page       <= rpage;
      rsp_reg.page_was_freed    <= freed;
      rsp_reg.batch_freed_total <= batch_after;
      rsp_reg.free_page_total   <= depth_next;
    end
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (cmd.commit && push) stack_mem[depth[PAGE_BITS-1:0]] <= item.page_id;
    stack_rd <= stack_mem[stack_raddr];
  end

  // count memory write port: clearing pass or item write-back
  always_comb begin
    cmem_we    = cmd.clear || (cmd.commit && cnt_we);
    cmem_waddr = cmd.clear ? clr_addr : item.page_id;
    cmem_wdata = cmd.clear ? '0 : sum[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmem_we) count_mem[cmem_waddr] <= cmem_wdata;
    count_rd <= count_mem[count_raddr];
  end

endmodule

// ===== rtl/refcounted_page_free_list_core.sv =====
`timescale 1ns / 1ps
// refcounted_page_free_list_core: top level of the page allocator with
// reference counts; depends on rcfl_pkg, rcfl_ctrl and rcfl_dpath

// Page allocator over 8192 pages with a LIFO free stack and a 16-bit
// reference count per page. For each item the block first reads the count
// memory and the top of the free stack, then evaluates the item and writes
// the count memory and the free stack back as the item needs. One item is in
// flight at a time; the result waits in an output register, so the next item
// is taken while it is held. After reset the block runs a clearing pass over
// all 8192 entries of the count memory, with req_stall high, before it takes
// the first item. The free stack needs no pass: entries below a low-water
// mark read as their reset page.

module refcounted_page_free_list_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rcfl_pkg::rcfl_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rcfl_pkg::rcfl_rsp_t rsp
);
  import rcfl_pkg::*;

  rcfl_cmd_t  cmd;
  rcfl_stat_t dp_stat;

  // sequencer
  rcfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  // memories and evaluation
  rcfl_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .req     (req),
    .dp_stat (dp_stat),
    .rsp     (rsp)
  );

endmodule
